### sv/trpu_pkg.sv
// ----------------------------------------------------------------------------
// trpu_pkg
// Shared types and constants of the packed pattern row unpacker.
// ----------------------------------------------------------------------------
package trpu_pkg;

	localparam int CHANNELS  = 32;
	localparam int CH_W      = $clog2(CHANNELS);
	localparam int ROWS      = 64;
	localparam int ROW_OUT_W = 6;
	localparam int ROW_CNT_W = ($clog2(ROWS + 1) > ROW_OUT_W) ? $clog2(ROWS + 1) : ROW_OUT_W;

	localparam logic [7:0] NOTE_DEF = 8'd255;
	localparam logic [7:0] INS_DEF  = 8'd0;
	localparam logic [7:0] VOL_DEF  = 8'd255;
	localparam logic [7:0] EFF_DEF  = 8'd255;
	localparam logic [7:0] DAT_DEF  = 8'd0;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	typedef struct packed {
		logic [7:0] pattern_byte;
		logic       pattern_start;
	} in_item_t;

	typedef struct packed {
		logic [5:0] row_number;
		logic [4:0] channel_number;
		logic [7:0] note_value;
		logic [7:0] instrument_value;
		logic [7:0] volume_value;
		logic [7:0] effect_value;
		logic [7:0] effect_param;
		logic       row_last;
	} out_item_t;

	typedef struct packed {
		logic restart;
		logic load_flag;
		logic wr_note;
		logic wr_ins;
		logic wr_vol;
		logic wr_eff;
		logic wr_dat;
		logic issue;
		logic end_row;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       finished;
		logic       slot_free;
		logic       last_ch;
		logic [2:0] flag_ann;
	} ctrl_sts_t;

endpackage

### sv/trpu_ctrl.sv
// ----------------------------------------------------------------------------
// trpu_ctrl
// Byte parser and row drain sequencer of the pattern row unpacker.
// ----------------------------------------------------------------------------
module trpu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  trpu_pkg::in_item_t  byte_item,
	input  trpu_pkg::ctrl_sts_t sts,
	output trpu_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		PH_FLAG,
		PH_NOTE,
		PH_INS,
		PH_VOL,
		PH_EFF,
		PH_DAT
	} phase_t;

	typedef enum logic {
		ST_PARSE,
		ST_DRAIN
	} state_t;

	phase_t phase_q;
	state_t state_q;
	phase_t cur_phase;
	phase_t nxt_phase;
	logic   acc;
	logic   live;

	// ann: flag bits 7..5; lvl: 0 after the flag, 1 after instrument, 2 after volume
	function automatic phase_t next_phase(input logic [2:0] ann, input logic [1:0] lvl);
		phase_t p;
		p = PH_FLAG;
		if (lvl == 2'd0 && ann[0]) begin
			p = PH_NOTE;
		end else if (lvl != 2'd2 && ann[1]) begin
			p = PH_VOL;
		end else if (ann[2]) begin
			p = PH_EFF;
		end
		return p;
	endfunction

	assign byte_stall = (state_q == ST_DRAIN);
	assign acc        = byte_valid && !byte_stall;
	assign live       = byte_item.pattern_start || !sts.finished;
	assign cur_phase  = byte_item.pattern_start ? PH_FLAG : phase_q;

	always_comb begin
		cmd       = '0;
		nxt_phase = phase_q;
		cmd.restart = acc && byte_item.pattern_start;
		if (acc && live) begin
			case (cur_phase)
				PH_NOTE: begin
					cmd.wr_note = 1'b1;
					nxt_phase   = PH_INS;
				end
				PH_INS: begin
					cmd.wr_ins = 1'b1;
					nxt_phase  = next_phase(sts.flag_ann, 2'd1);
				end
				PH_VOL: begin
					cmd.wr_vol = 1'b1;
					nxt_phase  = next_phase(sts.flag_ann, 2'd2);
				end
				PH_EFF: begin
					cmd.wr_eff = 1'b1;
					nxt_phase  = PH_DAT;
				end
				PH_DAT: begin
					cmd.wr_dat = 1'b1;
					nxt_phase  = PH_FLAG;
				end
				default: begin
					if (byte_item.pattern_byte != 8'd0) begin
						cmd.load_flag = 1'b1;
						nxt_phase     = next_phase(byte_item.pattern_byte[7:5], 2'd0);
					end else begin
						nxt_phase = PH_FLAG;
					end
				end
			endcase
		end
		if (state_q == ST_DRAIN) begin
			cmd.issue   = sts.slot_free;
			cmd.end_row = sts.slot_free && sts.last_ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			state_q <= ST_PARSE;
		end else begin
			case (state_q)
				ST_PARSE: begin
					if (acc && live) begin
						phase_q <= nxt_phase;
						// zero flag byte closes the row
						if (cur_phase == PH_FLAG && byte_item.pattern_byte == 8'd0) begin
							state_q <= ST_DRAIN;
						end
					end else if (cmd.restart) begin
						phase_q <= PH_FLAG;
					end
				end
				ST_DRAIN: begin
					if (cmd.end_row) begin
						state_q <= ST_PARSE;
					end
				end
				default: begin
					state_q <= ST_PARSE;
				end
			endcase
		end
	end

endmodule

### sv/trpu_dp.sv
// ----------------------------------------------------------------------------
// trpu_dp
// Row store, held flag, row counter and output register of the unpacker.
// ----------------------------------------------------------------------------
module trpu_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  trpu_pkg::in_item_t  byte_item,
	input  trpu_pkg::ctrl_cmd_t cmd,
	output trpu_pkg::ctrl_sts_t sts,
	output logic                entry_valid,
	input  logic                entry_stall,
	output trpu_pkg::out_item_t entry_item
);

	logic [7:0] note_q [trpu_pkg::CHANNELS];
	logic [7:0] ins_q  [trpu_pkg::CHANNELS];
	logic [7:0] vol_q  [trpu_pkg::CHANNELS];
	logic [7:0] eff_q  [trpu_pkg::CHANNELS];
	logic [7:0] dat_q  [trpu_pkg::CHANNELS];

	logic [trpu_pkg::CHANNELS-1:0]  note_vld_q;
	logic [trpu_pkg::CHANNELS-1:0]  ins_vld_q;
	logic [trpu_pkg::CHANNELS-1:0]  vol_vld_q;
	logic [trpu_pkg::CHANNELS-1:0]  eff_vld_q;
	logic [trpu_pkg::CHANNELS-1:0]  dat_vld_q;

	logic [7:0]                     flag_q;
	logic [trpu_pkg::ROW_CNT_W-1:0] row_cnt_q;
	logic [trpu_pkg::CH_W-1:0]      dcnt_q;
	logic                           out_valid_q;
	trpu_pkg::out_item_t            out_q;
	trpu_pkg::out_item_t            rd_item;
	logic [trpu_pkg::CH_W-1:0]      wr_ch;
	logic                           clear_vld;

	assign wr_ch     = flag_q[trpu_pkg::CH_W-1:0];
	assign clear_vld = cmd.restart || cmd.end_row;

	// store payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.wr_note) note_q[wr_ch] <= byte_item.pattern_byte;
		if (cmd.wr_ins)  ins_q[wr_ch]  <= byte_item.pattern_byte;
		if (cmd.wr_vol)  vol_q[wr_ch]  <= byte_item.pattern_byte;
		if (cmd.wr_eff)  eff_q[wr_ch]  <= byte_item.pattern_byte;
		if (cmd.wr_dat)  dat_q[wr_ch]  <= byte_item.pattern_byte;
	end

	// a field without its valid bit reads as the default
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_vld_q <= '0;
			ins_vld_q  <= '0;
			vol_vld_q  <= '0;
			eff_vld_q  <= '0;
			dat_vld_q  <= '0;
		end else if (clear_vld) begin
			note_vld_q <= '0;
			ins_vld_q  <= '0;
			vol_vld_q  <= '0;
			eff_vld_q  <= '0;
			dat_vld_q  <= '0;
		end else begin
			if (cmd.wr_note) note_vld_q[wr_ch] <= 1'b1;
			if (cmd.wr_ins)  ins_vld_q[wr_ch]  <= 1'b1;
			if (cmd.wr_vol)  vol_vld_q[wr_ch]  <= 1'b1;
			if (cmd.wr_eff)  eff_vld_q[wr_ch]  <= 1'b1;
			if (cmd.wr_dat)  dat_vld_q[wr_ch]  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= '0;
			row_cnt_q <= '0;
			dcnt_q    <= '0;
		end else begin
			// a flag byte that starts a pattern wins over the clear
			if (cmd.load_flag) begin
				flag_q <= byte_item.pattern_byte;
			end else if (cmd.restart || cmd.end_row) begin
				flag_q <= '0;
			end
			if (cmd.restart) begin
				row_cnt_q <= '0;
			end else if (cmd.end_row) begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end
			// wraps to channel zero after the last channel
			if (cmd.issue) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		rd_item.row_number       = row_cnt_q[trpu_pkg::ROW_OUT_W-1:0];
		rd_item.channel_number   = dcnt_q;
		rd_item.note_value       = note_vld_q[dcnt_q] ? note_q[dcnt_q] : trpu_pkg::NOTE_DEF;
		rd_item.instrument_value = ins_vld_q[dcnt_q]  ? ins_q[dcnt_q]  : trpu_pkg::INS_DEF;
		rd_item.volume_value     = vol_vld_q[dcnt_q]  ? vol_q[dcnt_q]  : trpu_pkg::VOL_DEF;
		rd_item.effect_value     = eff_vld_q[dcnt_q]  ? eff_q[dcnt_q]  : trpu_pkg::EFF_DEF;
		rd_item.effect_param     = dat_vld_q[dcnt_q]  ? dat_q[dcnt_q]  : trpu_pkg::DAT_DEF;
		rd_item.row_last         = (dcnt_q == trpu_pkg::LAST_CH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.issue) begin
			out_valid_q <= 1'b1;
		end else if (!entry_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			out_q <= rd_item;
		end
	end

	assign entry_valid   = out_valid_q;
	assign entry_item    = out_q;
	assign sts.slot_free = !out_valid_q || !entry_stall;
	assign sts.last_ch   = (dcnt_q == trpu_pkg::LAST_CH);
	assign sts.finished  = (row_cnt_q >= trpu_pkg::ROW_CNT_W'(trpu_pkg::ROWS));
	assign sts.flag_ann  = flag_q[7:5];

	a_issue_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sts.slot_free)
		else $error("entry issued into an occupied output register");

	a_no_wr_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !(cmd.wr_note || cmd.wr_ins || cmd.wr_vol || cmd.wr_eff || cmd.wr_dat))
		else $error("row store written while draining");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= trpu_pkg::ROW_CNT_W'(trpu_pkg::ROWS))
		else $error("row counter past pattern length");

	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_row |=> (dcnt_q == '0) && out_q.row_last && (note_vld_q == '0))
		else $error("row end did not wrap drain counter and clear store");

endmodule

### sv/tracker_pattern_row_unpacker.sv
// ----------------------------------------------------------------------------
// tracker_pattern_row_unpacker
// Decodes a packed tracker pattern stream into per-channel row entries.
// ----------------------------------------------------------------------------
// Input stalls only while a row drains; otherwise flag and payload bytes are accepted.
// A zero flag byte drains the 32-entry row store through the output register, one
// entry per cycle while the output is not stalled, starting once the drain state is entered.
// Throughput is set by the drain: one entry per cycle when the output is not stalled.
// Asynchronous active-low reset clears parser, row counter and store valid bits.
module tracker_pattern_row_unpacker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  trpu_pkg::in_item_t  byte_item,
	output logic                entry_valid,
	input  logic                entry_stall,
	output trpu_pkg::out_item_t entry_item
);

	trpu_pkg::ctrl_cmd_t cmd;
	trpu_pkg::ctrl_sts_t sts;

	trpu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.sts        (sts),
		.cmd        (cmd)
	);

	trpu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_item   (byte_item),
		.cmd         (cmd),
		.sts         (sts),
		.entry_valid (entry_valid),
		.entry_stall (entry_stall),
		.entry_item  (entry_item)
	);

endmodule
